// File: sv/priority_queue_max_extract_defines.svh
// Assertion macros for the priority queue
`ifndef PRIORITY_QUEUE_MAX_EXTRACT_DEFINES_SVH
`define PRIORITY_QUEUE_MAX_EXTRACT_DEFINES_SVH

// same-cycle implication
`define PQME_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PQME_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/pqme_pkg.sv
package pqme_pkg;

	localparam int PQME_CAPACITY = 16;

	localparam int VALUE_W  = 32;
	localparam int PRIO_W   = 16;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 5;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                     valid;
		logic signed [PRIO_W-1:0]  prio;
		logic signed [VALUE_W-1:0] value;
	} pqme_slot_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} pqme_ctrl_t;

endpackage

// File: sv/pqme_cell.sv
// One slot of the sorted chain; highest priority sits in the first cell,
// ties kept oldest first.
module pqme_cell
	import pqme_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  pqme_ctrl_t               ctrl,
	input  logic signed [VALUE_W-1:0] new_value,
	input  logic signed [PRIO_W-1:0]  new_prio,
	input  pqme_slot_t               left,
	input  logic                     left_ge,
	input  pqme_slot_t               right,
	output pqme_slot_t               slot,
	output logic                     ge_out
);

	logic                      valid_q;
	logic signed [PRIO_W-1:0]  prio_q;
	logic signed [VALUE_W-1:0] value_q;
	pqme_slot_t slot_q;
	pqme_slot_t slot_d;

	assign slot_q = '{valid: valid_q, prio: prio_q, value: value_q};
	assign ge_out = slot_q.valid && (slot_q.prio >= new_prio);
	assign slot   = slot_q;

	always_comb begin
		slot_d = slot_q;
		priority if (ctrl.rem) begin
			slot_d = right;
		end else if (ctrl.ins && !ge_out) begin
			if (left_ge) begin
				slot_d.prio  = new_prio;
				slot_d.value = new_value;
			end else begin
				slot_d.prio  = left.prio;
				slot_d.value = left.value;
			end
			slot_d.valid = slot_q.valid | left.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= slot_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		prio_q  <= slot_d.prio;
		value_q <= slot_d.value;
	end

endmodule

// File: sv/priority_queue_max_extract.sv
// Result: strobed on done in the cycle after start is taken.
// Busy is high while the result is shown, so no new start is taken until the last result has been strobed.
// All cells update together from their neighbours.
// Reset clears the valid bits, entry count and result strobe; slot contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "priority_queue_max_extract_defines.svh"

module priority_queue_max_extract
	import pqme_pkg::*;
#(
	parameter int CAPACITY = PQME_CAPACITY
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      req_type,
	input  logic signed [VALUE_W-1:0]  item_value,
	input  logic signed [PRIO_W-1:0]   item_priority,
	output logic                      done,
	output logic signed [VALUE_W-1:0]  out_value,
	output logic [STATUS_W-1:0]        status,
	output logic [FILL_W-1:0]          fill_level
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	pqme_slot_t       slots    [CAPACITY];
	pqme_slot_t       left_in  [CAPACITY];
	pqme_slot_t       right_in [CAPACITY];
	logic             ge       [CAPACITY];
	logic             left_ge  [CAPACITY];
	logic [CAPACITY-1:0] valid_vec;

	pqme_ctrl_t ctrl;
	logic       accept;
	logic       full;
	logic       empty;

	logic                     done_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic [STATUS_W-1:0]       status_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_d;
	logic [CNT_W+FILL_W-1:0]   count_ext;

	assign accept = start && !busy;
	assign busy   = done_q;
	assign full   = slots[CAPACITY-1].valid;
	assign empty  = !slots[0].valid;

	assign ctrl.ins = accept && (req_type == REQ_INSERT) && !full;
	assign ctrl.rem = accept && (req_type == REQ_REMOVE) && !empty;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			valid_vec[i] = slots[i].valid;
			if (i == 0) begin
				left_in[i] = '{valid: 1'b1, prio: '0, value: '0};
				left_ge[i] = 1'b1;
			end else begin
				left_in[i] = slots[i-1];
				left_ge[i] = ge[i-1];
			end
			if (i == CAPACITY - 1) begin
				right_in[i] = '0;
			end else begin
				right_in[i] = slots[i+1];
			end
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		pqme_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_value (item_value),
			.new_prio  (item_priority),
			.left      (left_in[g]),
			.left_ge   (left_ge[g]),
			.right     (right_in[g]),
			.slot      (slots[g]),
			.ge_out    (ge[g])
		);
	end

	always_comb begin
		count_d = count_q;
		priority if (ctrl.ins) begin
			count_d = count_q + 1'b1;
		end else if (ctrl.rem) begin
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q  <= accept;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_value_q <= ctrl.rem ? slots[0].value : '0;
			priority if (req_type == REQ_INSERT && full) begin
				status_q <= ST_FULL;
			end else if (req_type == REQ_REMOVE && empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_DONE;
			end
		end
	end

	assign count_ext  = {{FILL_W{1'b0}}, count_q};
	assign done       = done_q;
	assign out_value  = out_value_q;
	assign status     = status_q;
	assign fill_level = count_ext[FILL_W-1:0];

	`PQME_ASSERT_NEXT(a_result_follows, accept, done, "no result after accepted item")
	`PQME_ASSERT_IMPL(a_count_matches, 1'b1, $countones(valid_vec) == count_q,
		"entry count differs from valid cells")
	`PQME_ASSERT_IMPL(a_head_sorted, slots[1].valid, slots[0].prio >= slots[1].prio,
		"head cell not highest priority")
	`PQME_ASSERT_NEXT(a_remove_count, ctrl.rem, count_q == $past(count_q) - 1'b1,
		"removal did not decrement count")

endmodule

// File: tb/priority_queue_max_extract_tb.sv
module priority_queue_max_extract_tb;
	import pqme_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_ITEMS = 475;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [STATUS_W-1:0]       status;
		logic [FILL_W-1:0]         fill;
	} pq_result_t;

	typedef struct packed {
		logic                      req;
		logic signed [VALUE_W-1:0] value;
		logic signed [PRIO_W-1:0]  prio;
		bit                        typed;
		pq_result_t                want;
	} stim_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      req_type;
	logic signed [VALUE_W-1:0] item_value;
	logic signed [PRIO_W-1:0]  item_priority;
	logic                      done;
	logic signed [VALUE_W-1:0] out_value;
	logic [STATUS_W-1:0]       status;
	logic [FILL_W-1:0]         fill_level;

	// shadow of the queue contents, oldest entry in slot 0
	logic signed [VALUE_W-1:0] queue_value [PQME_CAPACITY];
	logic signed [PRIO_W-1:0]  queue_prio [PQME_CAPACITY];
	int                        queue_fill;

	pq_result_t pending_results [$];
	int         errors;
	int         idle_pct;
	int         stall_cycles;

	priority_queue_max_extract dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.item_value(item_value),
		.item_priority(item_priority),
		.done(done),
		.out_value(out_value),
		.status(status),
		.fill_level(fill_level)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic pq_result_t apply_request(input logic req,
			input logic signed [VALUE_W-1:0] v, input logic signed [PRIO_W-1:0] p);
		pq_result_t r;
		int best;
		r.value = '0;
		r.status = ST_DONE;
		if (req == REQ_INSERT) begin
			if (queue_fill >= PQME_CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				queue_value[queue_fill] = v;
				queue_prio[queue_fill] = p;
				queue_fill++;
			end
		end else if (queue_fill == 0) begin
			r.status = ST_EMPTY;
		end else begin
			// strict compare keeps the oldest of a tie
			best = 0;
			for (int i = 1; i < queue_fill; i++) begin
				if (queue_prio[i] > queue_prio[best])
					best = i;
			end
			r.value = queue_value[best];
			for (int i = best; i + 1 < queue_fill; i++) begin
				queue_value[i] = queue_value[i + 1];
				queue_prio[i] = queue_prio[i + 1];
			end
			queue_fill--;
		end
		r.fill = queue_fill[FILL_W-1:0];
		return r;
	endfunction

	function automatic stim_row_t mk_row(input logic req, input logic [VALUE_W-1:0] v,
			input logic [PRIO_W-1:0] p, input bit typed, input logic [STATUS_W-1:0] st,
			input int fill);
		stim_row_t row;
		row.req = req;
		row.value = v;
		row.prio = p;
		row.typed = typed;
		row.want.value = '0;
		row.want.status = st;
		row.want.fill = fill[FILL_W-1:0];
		return row;
	endfunction

	task automatic issue_request(input logic req, input logic signed [VALUE_W-1:0] v,
			input logic signed [PRIO_W-1:0] p, input bit typed, input pq_result_t want);
		pq_result_t predicted;
		bit taken;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			if ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				req_type <= req;
				item_value <= v;
				item_priority <= p;
				@(posedge clk);
				if (!busy) begin
					taken = 1'b1;
					predicted = apply_request(req, v, p);
					pending_results.push_back(typed ? want : predicted);
				end
			end
		end
	endtask

	always @(posedge clk) begin : check_results
		pq_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected item: value %0d status %0d fill %0d",
					$time, out_value, status, fill_level);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (out_value !== want.value) begin
					$display("%0t: out_value expected %0d got %0d", $time, want.value, out_value);
					errors++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status, status);
					errors++;
				end
				if (fill_level !== want.fill) begin
					$display("%0t: fill_level expected %0d got %0d", $time, want.fill, fill_level);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("priority_queue_max_extract_tb: done, errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		stim_row_t rows [24];
		pq_result_t none;
		logic req;
		logic signed [VALUE_W-1:0] v;
		logic signed [PRIO_W-1:0] p;
		int sent;
		int seg_len;
		int ins_bias;

		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_INSERT;
		item_value = '0;
		item_priority = '0;
		errors = 0;
		idle_pct = 0;
		queue_fill = 0;
		none = '0;

		rows[0]  = mk_row(REQ_REMOVE, 32'h0000_0000, 16'h0000, 1'b1, ST_EMPTY, 0);
		rows[1]  = mk_row(REQ_INSERT, 32'h7FFF_FFFF, 16'h8000, 1'b1, ST_DONE, 1);
		rows[2]  = mk_row(REQ_INSERT, 32'h8000_0000, 16'h7FFF, 1'b1, ST_DONE, 2);
		rows[3]  = mk_row(REQ_INSERT, 32'h0000_0000, 16'h0000, 1'b1, ST_DONE, 3);
		rows[4]  = mk_row(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, ST_DONE, 4);
		rows[5]  = mk_row(REQ_INSERT, 32'h1234_5678, 16'h7FFF, 1'b1, ST_DONE, 5);
		rows[6]  = mk_row(REQ_INSERT, 32'h5555_5555, 16'h0005, 1'b1, ST_DONE, 6);
		rows[7]  = mk_row(REQ_INSERT, 32'hAAAA_AAAA, 16'h0005, 1'b1, ST_DONE, 7);
		rows[8]  = mk_row(REQ_INSERT, 32'h0F0F_0F0F, 16'h8000, 1'b1, ST_DONE, 8);
		rows[9]  = mk_row(REQ_INSERT, 32'hF0F0_F0F0, 16'h0005, 1'b1, ST_DONE, 9);
		rows[10] = mk_row(REQ_INSERT, 32'h0000_0001, 16'h0001, 1'b1, ST_DONE, 10);
		rows[11] = mk_row(REQ_INSERT, 32'h8000_0001, 16'hFFFE, 1'b1, ST_DONE, 11);
		rows[12] = mk_row(REQ_INSERT, 32'h7FFF_FFFE, 16'h7FFE, 1'b1, ST_DONE, 12);
		rows[13] = mk_row(REQ_INSERT, 32'h3333_3333, 16'h0000, 1'b1, ST_DONE, 13);
		rows[14] = mk_row(REQ_INSERT, 32'hCCCC_CCCC, 16'h4000, 1'b1, ST_DONE, 14);
		rows[15] = mk_row(REQ_INSERT, 32'h00FF_00FF, 16'hC000, 1'b1, ST_DONE, 15);
		rows[16] = mk_row(REQ_INSERT, 32'hFF00_FF00, 16'h0005, 1'b1, ST_DONE, 16);
		rows[17] = mk_row(REQ_INSERT, 32'hDEAD_BEEF, 16'h7FFF, 1'b1, ST_FULL, 16);
		for (int i = 18; i < 24; i++)
			rows[i] = mk_row(REQ_REMOVE, $urandom, PRIO_W'($urandom_range(0, 65535)), 1'b0,
				ST_DONE, 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			issue_request(rows[i].req, rows[i].value, rows[i].prio, rows[i].typed, rows[i].want);

		// no idling, sender gaps, no idling again, light gaps
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				1: idle_pct = 80;
				3: idle_pct = 21;
				default: idle_pct = 0;
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				seg_len = $urandom_range(8, 48);
				case ($urandom_range(2))
					0: ins_bias = 90;
					1: ins_bias = 50;
					default: ins_bias = 15;
				endcase
				for (int k = 0; k < seg_len; k++) begin
					req = ($urandom_range(99) < ins_bias) ? REQ_INSERT : REQ_REMOVE;
					v = $urandom;
					case ($urandom_range(3))
						0, 1: p = PRIO_W'($urandom_range(0, 6)) - PRIO_W'(3);
						2: p = PRIO_W'($urandom_range(0, 65535));
						default: begin
							case ($urandom_range(3))
								0: p = 16'sh8000;
								1: p = 16'sh7FFF;
								2: p = 16'sh0000;
								default: p = 16'shFFFF;
							endcase
						end
					endcase
					issue_request(req, v, p, 1'b0, none);
					sent++;
				end
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (pending_results.size() != 0) begin
			$display("%0t: %0d expected items never arrived", $time, pending_results.size());
			errors++;
		end
		if (errors == 0) begin
			$display("priority_queue_max_extract_tb: done, clean");
		end else begin
			$display("priority_queue_max_extract_tb: done, errors");
		end
		$finish;
	end

endmodule
